### hdl/assert_macros.svh
// Assertion macros shared by the baseband synthesizer modules.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define GMBS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GMBS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/gmbs_pkg.sv
// Shared types, constants and the sine table for the baseband synthesizer.
// No dependencies.
package gmbs_pkg;

    localparam int GMBS_CHANNELS   = 16;
    localparam int GMBS_CODE_DEPTH = 2048;
    localparam int GMBS_NAV_WORDS  = 64;

    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_CHIP  = 3'd1;
    localparam logic [2:0] CMD_NAV   = 3'd2;
    localparam logic [2:0] CMD_NH    = 3'd3;
    localparam logic [2:0] CMD_FIELD = 3'd4;

    localparam logic [13:0] FLD_ACTIVE    = 14'd0;
    localparam logic [13:0] FLD_NH_EN     = 14'd1;
    localparam logic [13:0] FLD_GAIN      = 14'd2;
    localparam logic [13:0] FLD_CARR_PH   = 14'd3;
    localparam logic [13:0] FLD_CARR_STEP = 14'd4;
    localparam logic [13:0] FLD_CODE_PH   = 14'd5;
    localparam logic [13:0] FLD_CODE_STEP = 14'd6;
    localparam logic [13:0] FLD_CODE_LEN  = 14'd7;
    localparam logic [13:0] FLD_CODE_CNT  = 14'd8;
    localparam logic [13:0] FLD_BIT_CNT   = 14'd9;
    localparam logic [13:0] FLD_WORD_CNT  = 14'd10;
    localparam logic [13:0] FLD_SIGNS     = 14'd11;

    localparam int NH_LEN = 20;

    typedef struct packed {
        logic [2:0]  command;
        logic [3:0]  channel;
        logic [13:0] index;
        logic [43:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] i_sample;
        logic signed [15:0] q_sample;
    } out_item_t;

    typedef struct packed {
        logic clear;
        logic en;
        logic sel_q;
        logic negate;
    } mac_ctrl_t;

    typedef struct packed {
        logic chip_we;
        logic nav_we;
        logic rd_en;
    } store_ctrl_t;

    localparam logic [7:0] QUARTER_WAVE [128] = '{
        8'd2, 8'd5, 8'd8, 8'd11, 8'd14, 8'd17, 8'd20, 8'd23, 8'd26, 8'd29, 8'd32, 8'd35,
        8'd38, 8'd41, 8'd44, 8'd47, 8'd50, 8'd53, 8'd56, 8'd59, 8'd62, 8'd65, 8'd68,
        8'd71, 8'd74, 8'd77, 8'd80, 8'd83, 8'd86, 8'd89, 8'd91, 8'd94, 8'd97, 8'd100,
        8'd103, 8'd105, 8'd108, 8'd111, 8'd114, 8'd116, 8'd119, 8'd122, 8'd125, 8'd127,
        8'd130, 8'd132, 8'd135, 8'd138, 8'd140, 8'd143, 8'd145, 8'd148, 8'd150, 8'd153,
        8'd155, 8'd157, 8'd160, 8'd162, 8'd164, 8'd167, 8'd169, 8'd171, 8'd173, 8'd176,
        8'd178, 8'd180, 8'd182, 8'd184, 8'd186, 8'd188, 8'd190, 8'd192, 8'd194, 8'd196,
        8'd198, 8'd200, 8'd202, 8'd204, 8'd205, 8'd207, 8'd209, 8'd210, 8'd212, 8'd214,
        8'd215, 8'd217, 8'd218, 8'd220, 8'd221, 8'd223, 8'd224, 8'd225, 8'd227, 8'd228,
        8'd229, 8'd230, 8'd232, 8'd233, 8'd234, 8'd235, 8'd236, 8'd237, 8'd238, 8'd239,
        8'd240, 8'd241, 8'd241, 8'd242, 8'd243, 8'd244, 8'd244, 8'd245, 8'd245, 8'd246,
        8'd247, 8'd247, 8'd248, 8'd248, 8'd248, 8'd249, 8'd249, 8'd249, 8'd249, 8'd250,
        8'd250, 8'd250, 8'd250, 8'd250};

    // 512-point sine, mirrored from a quarter wave
    function automatic logic signed [8:0] sine_of(input logic [8:0] k);
        logic [7:0] q;
        logic [7:0] mag;
        q   = k[7:0];
        mag = q[7] ? QUARTER_WAVE[7'(8'd255 - q)] : QUARTER_WAVE[q[6:0]];
        return k[8] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

endpackage

### hdl/gmbs_mac.sv
// Shared multiply-accumulate unit: signed table value times unsigned gain into I or Q sum.
// Depends on gmbs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gmbs_mac import gmbs_pkg::*; #(
    parameter int ACC_W = 23
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  mac_ctrl_t               ctrl,
    input  logic signed [8:0]       tab_val,
    input  logic [7:0]              gain,
    output logic signed [ACC_W-1:0] i_acc,
    output logic signed [ACC_W-1:0] q_acc
);

    logic signed [ACC_W-1:0] i_acc_reg, i_acc_next;
    logic signed [ACC_W-1:0] q_acc_reg, q_acc_next;
    logic signed [17:0]      prod;
    logic signed [17:0]      term;

    always_comb begin
        prod = 18'(tab_val * $signed({1'b0, gain}));
        term = ctrl.negate ? -prod : prod;
        i_acc_next = i_acc_reg;
        q_acc_next = q_acc_reg;
        if (ctrl.clear) begin
            i_acc_next = '0;
            q_acc_next = '0;
        end else if (ctrl.en) begin
            if (ctrl.sel_q) begin
                q_acc_next = q_acc_reg + ACC_W'(term);
            end else begin
                i_acc_next = i_acc_reg + ACC_W'(term);
            end
        end
    end

    always_ff @(posedge aclk) begin
        i_acc_reg <= i_acc_next;
        q_acc_reg <= q_acc_next;
    end

    assign i_acc = i_acc_reg;
    assign q_acc = q_acc_reg;

    `GMBS_ASSERT_NEXT(a_clear_zero, aclk, aresetn, ctrl.clear, (i_acc_reg == '0) && (q_acc_reg == '0), "accumulators not cleared")

endmodule

### hdl/gmbs_stores.sv
// Spreading chip memory and navigation word memory, one write and one read port each.
// Depends on gmbs_pkg.
module gmbs_stores import gmbs_pkg::*; #(
    parameter int CH_W = 4,
    parameter int CA_W = 11,
    parameter int WC_W = 6
) (
    input  logic              aclk,
    input  store_ctrl_t       ctrl,
    input  logic [CH_W-1:0]   wr_ch,
    input  logic [CA_W-1:0]   wr_chip_addr,
    input  logic [WC_W-1:0]   wr_nav_addr,
    input  logic              wr_chip,
    input  logic [29:0]       wr_word,
    input  logic [CH_W-1:0]   rd_ch,
    input  logic [CA_W-1:0]   rd_chip_addr,
    input  logic [WC_W-1:0]   rd_nav_addr,
    output logic              chip_q,
    output logic [29:0]       word_q
);

    logic        chip_mem [2**(CH_W+CA_W)];
    logic [29:0] nav_mem  [2**(CH_W+WC_W)];

    always_ff @(posedge aclk) begin
        if (ctrl.chip_we) begin
            chip_mem[{wr_ch, wr_chip_addr}] <= wr_chip;
        end
        if (ctrl.rd_en) begin
            chip_q <= chip_mem[{rd_ch, rd_chip_addr}];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.nav_we) begin
            nav_mem[{wr_ch, wr_nav_addr}] <= wr_word;
        end
        if (ctrl.rd_en) begin
            word_q <= nav_mem[{rd_ch, rd_nav_addr}];
        end
    end

endmodule

### hdl/gnss_multichannel_baseband_synth_core.sv
// Channel    Ports                          Carries
// input      s_valid s_ready s_item         tick or store/field write item
// result     m_valid m_ready m_item         rounded, saturated I/Q sample
//
// Write items are accepted only in IDLE. A tick visits each channel: an inactive one
// only in MUL_I; an active one in MUL_I, MUL_Q, WRAP, SIGN, through one shared MAC
// unit (I then Q), a 43-bit phase add, a wrap subtract and a registered memory read.
// Reset restores channel fields; chip, nav and NH stores hold nothing defined.
// The result waits in an output register; a full register stalls the next tick.
// Depends on gmbs_pkg, gmbs_mac, gmbs_stores and assert_macros.svh.
`include "assert_macros.svh"

module gnss_multichannel_baseband_synth_core import gmbs_pkg::*; #(
    parameter int CHANNELS   = GMBS_CHANNELS,
    parameter int CODE_DEPTH = GMBS_CODE_DEPTH,
    parameter int NAV_WORDS  = GMBS_NAV_WORDS
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CA_W  = $clog2(CODE_DEPTH);
    localparam int MW    = (CA_W > 11) ? CA_W : 11;
    localparam int WC_W  = ($clog2(NAV_WORDS + 1) > 6) ? $clog2(NAV_WORDS) : 6;
    localparam int ACC_W = 19 + CH_W;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MUL_I = 6'b000010,
        ST_MUL_Q = 6'b000100,
        ST_WRAP  = 6'b001000,
        ST_SIGN  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t          state_reg, state_next;
    logic [CH_W-1:0] ch_reg, ch_next;
    logic [42:0]     sum_reg, sum_next;
    logic            bit_adv_reg, nh_upd_reg, nh_bit_reg;
    logic [4:0]      bc_new_reg;
    logic            m_valid_reg, m_valid_next;
    out_item_t       m_item_reg;

    // per-channel fields
    logic            act_reg   [CHANNELS];
    logic            nhen_reg  [CHANNELS];
    logic [7:0]      gain_reg  [CHANNELS];
    logic [24:0]     carr_reg  [CHANNELS];
    logic [24:0]     cstep_reg [CHANNELS];
    logic [42:0]     cph_reg   [CHANNELS];
    logic [33:0]     kstep_reg [CHANNELS];
    logic [11:0]     len_reg   [CHANNELS];
    logic [4:0]      cc_reg    [CHANNELS];
    logic [4:0]      bc_reg    [CHANNELS];
    logic [WC_W-1:0] wc_reg    [CHANNELS];
    logic [2:0]      sym_reg   [CHANNELS];
    logic [NH_LEN-1:0] nh_reg  [CHANNELS];

    logic            acc_in, ch_ok, last_ch;
    logic [CH_W-1:0] wch;
    logic            fld_we, nh_we;
    mac_ctrl_t       mac_ctrl;
    store_ctrl_t     st_ctrl;
    logic signed [8:0] cv, sv;
    logic [8:0]      k;
    logic signed [ACC_W-1:0] i_acc, q_acc;
    logic            chip_q;
    logic [29:0]     word_q;

    logic [44:0]     diff;
    logic            ge;
    logic [42:0]     ph_new;
    logic [4:0]      cc_inc, cc_new, bc_inc, bc_new;
    logic            badv, wadv;
    logic [WC_W:0]   wc_inc, wc_mod;
    logic [WC_W-1:0] wc_new;
    logic [MW-1:0]   int_ext, int_mod;
    logic [CA_W-1:0] rd_chip_addr;
    logic [WC_W-1:0] rd_nav_addr;
    logic            nav_bit;
    logic [4:0]      nav_sh;

    assign acc_in  = s_valid && s_ready;
    assign ch_ok   = 6'(s_item.channel) < 6'(CHANNELS);
    assign wch     = CH_W'(s_item.channel);
    assign fld_we  = acc_in && (s_item.command == CMD_FIELD) && ch_ok;
    assign nh_we   = acc_in && (s_item.command == CMD_NH) && ch_ok
                     && (s_item.index < 14'(NH_LEN));
    assign last_ch = (ch_reg == CH_W'(CHANNELS - 1));

    assign k  = carr_reg[ch_reg][24:16];
    assign cv = sine_of(k + 9'd128);
    assign sv = sine_of(k);

    always_comb begin
        mac_ctrl.clear  = acc_in && (s_item.command == CMD_TICK);
        mac_ctrl.en     = ((state_reg == ST_MUL_I) && act_reg[ch_reg])
                          || (state_reg == ST_MUL_Q);
        mac_ctrl.sel_q  = (state_reg == ST_MUL_Q);
        mac_ctrl.negate = ^sym_reg[ch_reg];
    end

    // phase wrap and counter chain for the current channel; the code limit
    // spans 44 bits, so the compare needs one more bit than the limit
    always_comb begin
        diff    = {2'b0, sum_reg} - {1'b0, len_reg[ch_reg], 32'd0};
        ge      = !diff[44];
        ph_new  = ge ? diff[42:0] : sum_reg;
        cc_inc  = cc_reg[ch_reg] + 5'd1;
        badv    = ge && (cc_inc >= 5'd20);
        cc_new  = !ge ? cc_reg[ch_reg] : (badv ? cc_inc - 5'd20 : cc_inc);
        bc_inc  = bc_reg[ch_reg] + 5'd1;
        wadv    = badv && (bc_inc >= 5'd30);
        bc_new  = !badv ? bc_reg[ch_reg] : (wadv ? bc_inc - 5'd30 : bc_inc);
        wc_inc  = (WC_W + 1)'(wc_reg[ch_reg]) + (WC_W + 1)'(1);
        wc_new  = !wadv ? wc_reg[ch_reg]
                  : ((wc_inc >= (WC_W + 1)'(NAV_WORDS)) ? '0 : WC_W'(wc_inc));
        wc_mod  = (WC_W + 1)'(wc_new);
        if (wc_mod >= (WC_W + 1)'(NAV_WORDS)) begin
            wc_mod = wc_mod - (WC_W + 1)'(NAV_WORDS);
        end
        rd_nav_addr = WC_W'(wc_mod);
        int_ext = MW'(ph_new[42:32]);
        int_mod = (int_ext >= MW'(CODE_DEPTH)) ? int_ext - MW'(CODE_DEPTH) : int_ext;
        rd_chip_addr = CA_W'(int_mod);
    end

    assign nav_sh  = 5'd29 - bc_new_reg;
    assign nav_bit = word_q[nav_sh];

    always_comb begin
        st_ctrl.chip_we = acc_in && (s_item.command == CMD_CHIP) && ch_ok
                          && (15'(s_item.index) < 15'(CODE_DEPTH));
        st_ctrl.nav_we  = acc_in && (s_item.command == CMD_NAV) && ch_ok
                          && (s_item.index < 14'(NAV_WORDS));
        st_ctrl.rd_en   = (state_reg == ST_WRAP);
    end

    gmbs_mac #(.ACC_W(ACC_W)) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mac_ctrl),
        .tab_val (mac_ctrl.sel_q ? sv : cv),
        .gain    (gain_reg[ch_reg]),
        .i_acc   (i_acc),
        .q_acc   (q_acc)
    );

    gmbs_stores #(.CH_W(CH_W), .CA_W(CA_W), .WC_W(WC_W)) u_stores (
        .aclk         (aclk),
        .ctrl         (st_ctrl),
        .wr_ch        (wch),
        .wr_chip_addr (CA_W'(s_item.index)),
        .wr_nav_addr  (WC_W'(s_item.index)),
        .wr_chip      (s_item.value[0]),
        .wr_word      (s_item.value[29:0]),
        .rd_ch        (ch_reg),
        .rd_chip_addr (rd_chip_addr),
        .rd_nav_addr  (rd_nav_addr),
        .chip_q       (chip_q),
        .word_q       (word_q)
    );

    // sequencer
    always_comb begin
        state_next   = state_reg;
        ch_next      = ch_reg;
        sum_next     = sum_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (acc_in && (s_item.command == CMD_TICK)) begin
                    state_next = ST_MUL_I;
                    ch_next    = '0;
                end
            end
            ST_MUL_I: begin
                if (act_reg[ch_reg]) begin
                    state_next = ST_MUL_Q;
                end else if (last_ch) begin
                    state_next = ST_DONE;
                end else begin
                    ch_next = ch_reg + CH_W'(1);
                end
            end
            ST_MUL_Q: begin
                sum_next   = cph_reg[ch_reg]
                             + {{9{kstep_reg[ch_reg][33]}}, kstep_reg[ch_reg]};
                state_next = ST_WRAP;
            end
            ST_WRAP: begin
                state_next = ST_SIGN;
            end
            ST_SIGN: begin
                if (last_ch) begin
                    state_next = ST_DONE;
                end else begin
                    ch_next    = ch_reg + CH_W'(1);
                    state_next = ST_MUL_I;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    function automatic logic signed [15:0] round_sat(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W:0] t;
        t = ($signed({a[ACC_W-1], a}) + $signed((ACC_W + 1)'(64))) >>> 7;
        if (t > $signed((ACC_W + 1)'(32767))) begin
            return 16'sd32767;
        end else if (t < -$signed((ACC_W + 1)'(32768))) begin
            return -16'sd32768;
        end
        return 16'(t);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ch_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ch_reg      <= ch_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg <= sum_next;
        if (state_reg == ST_WRAP) begin
            bit_adv_reg <= badv;
            nh_upd_reg  <= ge && nhen_reg[ch_reg];
            nh_bit_reg  <= nh_reg[ch_reg][cc_new];
            bc_new_reg  <= bc_new;
        end
        if ((state_reg == ST_DONE) && (!m_valid_reg || m_ready)) begin
            m_item_reg.i_sample <= round_sat(i_acc);
            m_item_reg.q_sample <= round_sat(q_acc);
        end
    end

    always_ff @(posedge aclk) begin
        if (nh_we) begin
            nh_reg[wch][5'(s_item.index)] <= s_item.value[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CHANNELS; c++) begin
                act_reg[c]   <= 1'b0;
                nhen_reg[c]  <= 1'b0;
                gain_reg[c]  <= 8'd128;
                carr_reg[c]  <= '0;
                cstep_reg[c] <= '0;
                cph_reg[c]   <= '0;
                kstep_reg[c] <= '0;
                len_reg[c]   <= '0;
                cc_reg[c]    <= '0;
                bc_reg[c]    <= '0;
                wc_reg[c]    <= '0;
                sym_reg[c]   <= '0;
            end
        end else begin
            if (fld_we) begin
                case (s_item.index)
                    FLD_ACTIVE:    act_reg[wch]   <= s_item.value[0];
                    FLD_NH_EN:     nhen_reg[wch]  <= s_item.value[0];
                    FLD_GAIN:      gain_reg[wch]  <= s_item.value[7:0];
                    FLD_CARR_PH:   carr_reg[wch]  <= s_item.value[24:0];
                    FLD_CARR_STEP: cstep_reg[wch] <= s_item.value[24:0];
                    FLD_CODE_PH:   cph_reg[wch]   <= s_item.value[42:0];
                    FLD_CODE_STEP: kstep_reg[wch] <= s_item.value[33:0];
                    FLD_CODE_LEN:  len_reg[wch]   <= s_item.value[11:0];
                    FLD_CODE_CNT:  cc_reg[wch]    <= s_item.value[4:0];
                    FLD_BIT_CNT:   bc_reg[wch]    <= s_item.value[4:0];
                    FLD_WORD_CNT:  wc_reg[wch]    <= WC_W'(s_item.value[5:0]);
                    FLD_SIGNS:     sym_reg[wch]   <= s_item.value[2:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_WRAP) begin
                cph_reg[ch_reg]  <= ph_new;
                cc_reg[ch_reg]   <= cc_new;
                bc_reg[ch_reg]   <= bc_new;
                wc_reg[ch_reg]   <= wc_new;
                carr_reg[ch_reg] <= carr_reg[ch_reg] + cstep_reg[ch_reg];
            end
            if (state_reg == ST_SIGN) begin
                sym_reg[ch_reg] <= {nh_upd_reg ? nh_bit_reg : sym_reg[ch_reg][2],
                                    bit_adv_reg ? nav_bit : sym_reg[ch_reg][1],
                                    chip_q};
            end
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    `GMBS_ASSERT(a_ch_range, aclk, aresetn, 6'(ch_reg) < 6'(CHANNELS), "channel counter out of range")
    `GMBS_ASSERT_NEXT(a_tick_start, aclk, aresetn, acc_in && (s_item.command == CMD_TICK), state_reg == ST_MUL_I && ch_reg == '0, "tick did not start channel loop")
    `GMBS_ASSERT_NEXT(a_wrap_sign, aclk, aresetn, state_reg == ST_WRAP, state_reg == ST_SIGN, "wrap not followed by sign update")
    `GMBS_ASSERT_NEXT(a_done_out, aclk, aresetn, (state_reg == ST_DONE) && (!m_valid_reg || m_ready), m_valid_reg, "finished tick gave no result")

endmodule
